// File: rtl/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, constants and helper functions for the complex arithmetic
// unit: operation codes, sequencer states, the CORDIC arctangent table and
// clipping helpers.
// ----------------------------------------------------------------------------
package cau_pkg;

	// Data format: Q2.13 parts
	localparam int DW     = 16;
	localparam int FRAC   = DW - 3;
	localparam int SW     = DW + 1;            // scalar output width minus DW
	localparam int SCW    = 2 * DW + 1;        // scalar output width
	localparam int OPW    = DW + 1;            // multiplier operand width
	localparam int PW     = 2 * OPW;           // product width
	localparam int XW     = 36;                // CORDIC x/y width
	localparam int ZW     = 34;                // CORDIC angle width
	localparam int CLW    = 40;                // clip helper input width
	localparam int ATAN_N = 24;

	localparam int DEF_CORDIC_STEPS = 16;
	localparam int DEF_MAX_EXPONENT = 15;

	// 1/K CORDIC gain correction, Q0.16
	localparam logic signed [OPW-1:0] INV_GAIN = 17'sd39797;
	localparam logic signed [ZW-1:0]  QUARTER  = 34'sd1073741824;

	localparam logic signed [CLW-1:0] SAT_HI = CLW'((64'sd1 <<< (DW - 1)) - 1);
	localparam logic signed [CLW-1:0] SAT_LO = -SAT_HI - 1;

	typedef enum logic [3:0] {
		K_ENERGY = 4'd0,
		K_ABS    = 4'd1,
		K_ANGLE  = 4'd2,
		K_POLAR  = 4'd3,
		K_CONJ   = 4'd4,
		K_ADD    = 4'd5,
		K_SUB    = 4'd6,
		K_MUL    = 4'd7,
		K_TJ     = 4'd8,
		K_TNJ    = 4'd9,
		K_POW    = 4'd10
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_MUL,
		ST_MRND,
		ST_CORD,
		ST_CFIN,
		ST_CSCL,
		ST_DONE
	} state_t;

	// arctan(2^-i) in binary angle with 16 guard bits (2^31 = pi)
	function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] i);
		logic signed [ZW-1:0] r;
		case (i)
			5'd0:  r = 34'sd536870912;
			5'd1:  r = 34'sd316933406;
			5'd2:  r = 34'sd167458907;
			5'd3:  r = 34'sd85004756;
			5'd4:  r = 34'sd42667331;
			5'd5:  r = 34'sd21354465;
			5'd6:  r = 34'sd10679838;
			5'd7:  r = 34'sd5340245;
			5'd8:  r = 34'sd2670163;
			5'd9:  r = 34'sd1335087;
			5'd10: r = 34'sd667544;
			5'd11: r = 34'sd333772;
			5'd12: r = 34'sd166886;
			5'd13: r = 34'sd83443;
			5'd14: r = 34'sd41722;
			5'd15: r = 34'sd20861;
			5'd16: r = 34'sd10430;
			5'd17: r = 34'sd5215;
			5'd18: r = 34'sd2608;
			5'd19: r = 34'sd1304;
			5'd20: r = 34'sd652;
			5'd21: r = 34'sd326;
			5'd22: r = 34'sd163;
			5'd23: r = 34'sd81;
			default: r = '0;
		endcase
		return r;
	endfunction

	// clip to the signed DW range
	function automatic logic signed [DW-1:0] clip_dw(input logic signed [CLW-1:0] v);
		logic signed [DW-1:0] r;
		if (v > SAT_HI)
			r = SAT_HI[DW-1:0];
		else if (v < SAT_LO)
			r = SAT_LO[DW-1:0];
		else
			r = v[DW-1:0];
		return r;
	endfunction

	function automatic logic clip_ovf(input logic signed [CLW-1:0] v);
		return (v > SAT_HI) || (v < SAT_LO);
	endfunction

endpackage

// File: rtl/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Fixed-point complex ALU with a shared complex multiplier and a shared
// CORDIC shift-add stage under one small sequencer.
// ----------------------------------------------------------------------------
// One request at a time. Add, subtract, conjugate and the j rotations are
// computed in the setup state; energy and multiply take one pass through the
// complex multiplier and its rounding stage; power takes one such pass per
// power step (n steps, n clipped to MAX_EXPONENT); magnitude, angle and polar
// conversion run CORDIC_STEPS rotations on the single CORDIC stage doing one
// rotation per cycle. The input stalls while a request is in flight; a
// finished result waits in the output register.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
	parameter int CORDIC_STEPS = cau_pkg::DEF_CORDIC_STEPS,
	parameter int MAX_EXPONENT = cau_pkg::DEF_MAX_EXPONENT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [3:0]                        kind,
	input  logic signed [cau_pkg::DW-1:0]     a_re,
	input  logic signed [cau_pkg::DW-1:0]     a_im,
	input  logic signed [cau_pkg::DW-1:0]     b_re,
	input  logic signed [cau_pkg::DW-1:0]     b_im,
	input  logic [cau_pkg::DW-1:0]            mag_in,
	input  logic signed [15:0]                ang_in,
	input  logic [3:0]                        exponent,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [cau_pkg::DW-1:0]     res_re,
	output logic signed [cau_pkg::DW-1:0]     res_im,
	output logic signed [cau_pkg::SCW-1:0]    scalar_out,
	output logic                              saturated
);
	import cau_pkg::*;

	localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam int NW = (MAX_EXPONENT > 1) ? $clog2(MAX_EXPONENT + 1) : 1;
	localparam logic [CW-1:0] C_LAST = CW'(CORDIC_STEPS - 1);

	state_t state_q, state_d;

	logic [3:0]              kind_q;
	logic signed [DW-1:0]    ar_q, ai_q, br_q, bi_q;
	logic [DW-1:0]           mag_q;
	logic signed [15:0]      ang_q;
	logic [NW-1:0]           pw_q;
	logic [CW-1:0]           cnt_q;

	// multiplier operands and products
	logic signed [OPW-1:0]   m_ar_q, m_ai_q, m_br_q, m_bi_q;
	logic signed [PW-1:0]    p0_q, p1_q, p2_q, p3_q;

	// CORDIC state
	logic signed [XW-1:0]    x_q, y_q;
	logic signed [ZW-1:0]    z_q;

	// staged result
	logic signed [DW-1:0]    rr_q, ri_q;
	logic signed [SCW-1:0]   sc_q;
	logic                    fl_q;

	logic                    accept, commit, out_free;
	logic                    is_vec, is_pow, cord_dir;
	logic [NW-1:0]           n_clip;
	logic signed [PW:0]      mre, mim;
	logic signed [PW:0]      mre_r, mim_r;
	logic signed [XW-1:0]    dx, dy;
	logic signed [ZW-1:0]    at;
	logic signed [XW-1:0]    vx0, vy0;
	logic signed [XW-1:0]    rx0;
	logic signed [ZW-1:0]    rz0;
	logic signed [XW-1:0]    x_r8;
	logic signed [ZW-17:0]   z_r16;
	logic signed [44:0]      gprod;
	logic signed [20:0]      gmag;
	logic signed [XW-17:0]   cx_r16, cy_r16;
	logic signed [DW+1:0]    s_add_re, s_add_im, s_sub_re, s_sub_im, neg_ai, neg_ar;

	// handshake and sequencing outputs
	always_comb begin
		out_free = !out_valid || !out_stall;
		in_stall = (state_q != ST_IDLE);
		accept   = in_valid && (state_q == ST_IDLE);
		commit   = (state_q == ST_DONE) && out_free;
	end

	assign is_vec = (kind_q == K_ABS) || (kind_q == K_ANGLE);
	assign is_pow = (kind_q == K_POW);
	assign n_clip = (int'(exponent) > MAX_EXPONENT) ? NW'(MAX_EXPONENT) : NW'(exponent);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_SETUP;
			ST_SETUP: begin
				priority if (kind_q == K_ENERGY || kind_q == K_MUL)
					state_d = ST_MUL;
				else if (is_pow)
					state_d = (pw_q == '0) ? ST_DONE : ST_MUL;
				else if (is_vec)
					state_d = (ar_q == '0 && ai_q == '0) ? ST_DONE : ST_CORD;
				else if (kind_q == K_POLAR)
					state_d = ST_CORD;
				else
					state_d = ST_DONE;
			end
			ST_MUL:   state_d = ST_MRND;
			ST_MRND:  state_d = (is_pow && pw_q > NW'(1)) ? ST_MUL : ST_DONE;
			ST_CORD:  if (cnt_q == C_LAST) state_d = ST_CFIN;
			ST_CFIN:  state_d = (kind_q == K_ABS) ? ST_CSCL : ST_DONE;
			ST_CSCL:  state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// complex product combine and round half up
	assign mre   = (PW+1)'(p0_q) - (PW+1)'(p1_q);
	assign mim   = (PW+1)'(p2_q) + (PW+1)'(p3_q);
	assign mre_r = (PW+1)'(mre + (PW+1)'(4096)) >>> FRAC;
	assign mim_r = (PW+1)'(mim + (PW+1)'(4096)) >>> FRAC;

	// one CORDIC micro-rotation
	assign dx       = y_q >>> cnt_q;
	assign dy       = x_q >>> cnt_q;
	assign at       = atan_lut(5'(cnt_q));
	assign cord_dir = is_vec ? (y_q <= 0) : (z_q >= 0);

	// vectoring pre-rotation into the right half plane
	assign vx0 = XW'(ar_q) <<< 16;
	assign vy0 = XW'(ai_q) <<< 16;

	// polar start vector with gain correction
	assign rx0 = XW'($signed({1'b0, mag_q})) * XW'(INV_GAIN);
	assign rz0 = ZW'(ang_q) <<< 16;

	// CORDIC rounding
	assign x_r8   = (x_q + XW'(128)) >>> 8;
	assign z_r16  = (ZW-16)'(ZW'(z_q + ZW'(32768)) >>> 16);
	assign cx_r16 = (XW-16)'(XW'(x_q + XW'(32768)) >>> 16);
	assign cy_r16 = (XW-16)'(XW'(y_q + XW'(32768)) >>> 16);
	assign gprod  = 45'($signed(x_q[27:0])) * 45'(INV_GAIN);
	assign gmag   = 21'((gprod + 45'sd8388608) >>> 24);

	// simple add/sub/negate
	assign s_add_re = (DW+2)'(ar_q) + (DW+2)'(br_q);
	assign s_add_im = (DW+2)'(ai_q) + (DW+2)'(bi_q);
	assign s_sub_re = (DW+2)'(ar_q) - (DW+2)'(br_q);
	assign s_sub_im = (DW+2)'(ai_q) - (DW+2)'(bi_q);
	assign neg_ai   = -(DW+2)'(ai_q);
	assign neg_ar   = -(DW+2)'(ar_q);

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (accept) begin
				kind_q <= kind;
				ar_q   <= a_re;
				ai_q   <= a_im;
				br_q   <= b_re;
				bi_q   <= b_im;
				mag_q  <= mag_in;
				ang_q  <= ang_in;
				pw_q   <= n_clip;
				rr_q   <= '0;
				ri_q   <= '0;
				sc_q   <= '0;
				fl_q   <= 1'b0;
			end
			ST_SETUP: begin
				cnt_q <= '0;
				unique case (kind_q)
					K_ENERGY: begin
						m_ar_q <= OPW'(ar_q);
						m_ai_q <= OPW'(ai_q);
						m_br_q <= OPW'(ar_q);
						m_bi_q <= -OPW'(ai_q);
					end
					K_MUL: begin
						m_ar_q <= OPW'(ar_q);
						m_ai_q <= OPW'(ai_q);
						m_br_q <= OPW'(br_q);
						m_bi_q <= OPW'(bi_q);
					end
					K_POW: begin
						m_ar_q <= OPW'(1 << FRAC);
						m_ai_q <= '0;
						m_br_q <= OPW'(ar_q);
						m_bi_q <= OPW'(ai_q);
						rr_q   <= DW'(1 << FRAC);
					end
					K_ABS, K_ANGLE: begin
						if (ar_q < 0) begin
							if (ai_q >= 0) begin
								x_q <= vy0;
								y_q <= -vx0;
								z_q <= QUARTER;
							end else begin
								x_q <= -vy0;
								y_q <= vx0;
								z_q <= -QUARTER;
							end
						end else begin
							x_q <= vx0;
							y_q <= vy0;
							z_q <= '0;
						end
					end
					K_POLAR: begin
						if (ang_q > 16'sd16384) begin
							x_q <= '0;
							y_q <= rx0;
							z_q <= rz0 - QUARTER;
						end else if (ang_q < -16'sd16384) begin
							x_q <= '0;
							y_q <= -rx0;
							z_q <= rz0 + QUARTER;
						end else begin
							x_q <= rx0;
							y_q <= '0;
							z_q <= rz0;
						end
					end
					K_CONJ: begin
						rr_q <= ar_q;
						ri_q <= clip_dw(CLW'(neg_ai));
						fl_q <= clip_ovf(CLW'(neg_ai));
					end
					K_ADD: begin
						rr_q <= clip_dw(CLW'(s_add_re));
						ri_q <= clip_dw(CLW'(s_add_im));
						fl_q <= clip_ovf(CLW'(s_add_re)) | clip_ovf(CLW'(s_add_im));
					end
					K_SUB: begin
						rr_q <= clip_dw(CLW'(s_sub_re));
						ri_q <= clip_dw(CLW'(s_sub_im));
						fl_q <= clip_ovf(CLW'(s_sub_re)) | clip_ovf(CLW'(s_sub_im));
					end
					K_TJ: begin
						rr_q <= clip_dw(CLW'(neg_ai));
						ri_q <= ar_q;
						fl_q <= clip_ovf(CLW'(neg_ai));
					end
					K_TNJ: begin
						rr_q <= ai_q;
						ri_q <= clip_dw(CLW'(neg_ar));
						fl_q <= clip_ovf(CLW'(neg_ar));
					end
					default: ;
				endcase
			end
			ST_MUL: begin
				p0_q <= PW'(m_ar_q) * PW'(m_br_q);
				p1_q <= PW'(m_ai_q) * PW'(m_bi_q);
				p2_q <= PW'(m_ar_q) * PW'(m_bi_q);
				p3_q <= PW'(m_ai_q) * PW'(m_br_q);
			end
			ST_MRND: begin
				if (kind_q == K_ENERGY) begin
					sc_q <= mre[SCW-1:0];
				end else begin
					rr_q   <= clip_dw(CLW'(mre_r));
					ri_q   <= clip_dw(CLW'(mim_r));
					fl_q   <= fl_q | clip_ovf(CLW'(mre_r)) | clip_ovf(CLW'(mim_r));
					m_ar_q <= OPW'(clip_dw(CLW'(mre_r)));
					m_ai_q <= OPW'(clip_dw(CLW'(mim_r)));
					pw_q   <= pw_q - NW'(1);
				end
			end
			ST_CORD: begin
				cnt_q <= cnt_q + CW'(1);
				if (cord_dir) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + at;
				end
			end
			ST_CFIN: begin
				x_q <= x_r8;
				if (kind_q == K_ANGLE) begin
					if (z_r16 > 18'sd32768)
						sc_q <= SCW'(32768);
					else if (z_r16 < -18'sd32768)
						sc_q <= -SCW'(32768);
					else
						sc_q <= SCW'(z_r16);
				end
				if (kind_q == K_POLAR) begin
					rr_q <= clip_dw(CLW'(cx_r16));
					ri_q <= clip_dw(CLW'(cy_r16));
					fl_q <= clip_ovf(CLW'(cx_r16)) | clip_ovf(CLW'(cy_r16));
				end
			end
			ST_CSCL: begin
				if (gmag > 21'sd65535)
					sc_q <= SCW'(65535);
				else
					sc_q <= SCW'(gmag);
			end
			ST_DONE: ;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (commit)
			out_valid <= 1'b1;
		else if (!out_stall)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			res_re     <= rr_q;
			res_im     <= ri_q;
			scalar_out <= sc_q;
			saturated  <= fl_q;
		end
	end

`ifndef SYNTHESIS
	// an accepted request always enters setup next
	a_accept_setup: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == ST_SETUP)
		else $error("accepted request did not enter setup");

	// CORDIC counter stays inside the configured step count
	a_cord_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CORD |-> int'(cnt_q) < CORDIC_STEPS)
		else $error("CORDIC step counter out of range");

	// a clipped result never carries a scalar
	a_flag_scalar: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> scalar_out == '0)
		else $error("saturation flag on a scalar result");

	// a result is only loaded into a free output register
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> !(out_valid && out_stall))
		else $error("output register overwritten while stalled");
`endif

endmodule
